### hw/rtl/erl_pkg.sv
// Shared types and constants for the event record ring log.
`default_nettype none

package erl_pkg;

  // Command codes on the request channel.
  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_DRAIN   = 2'd2
  } cmd_code_t;

  // Most records one drain delivers.
  localparam int MAX_DRAIN = 32;
  localparam int DRN_CW    = $clog2(MAX_DRAIN + 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CAP,
    S_READ,
    S_READ_WAIT,
    S_DRN_INIT,
    S_DRN_RD,
    S_DRN_CHK,
    S_DRN_END
  } state_t;

  typedef enum logic [2:0] {
    OUT_CAP,
    OUT_READ,
    OUT_PEND_MID,
    OUT_PEND_LAST,
    OUT_EMPTY
  } out_sel_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [7:0]  kind_in;
    logic [7:0]         cpu_id;
    logic signed [31:0] proc_id;
    logic signed [31:0] fault_code;
    logic [63:0]        prog_counter;
    logic [63:0]        fault_addr;
    logic [31:0]        time_ms;
    logic [4:0]         read_index;
  } req_item_t;

  typedef struct packed {
    logic               valid_res;
    logic [31:0]        seq_out;
    logic [31:0]        time_out;
    logic [3:0]         kind_out;
    logic [7:0]         cpu_out;
    logic signed [31:0] pid_out;
    logic signed [31:0] code_out;
    logic [63:0]        pc_out;
    logic [63:0]        addr_out;
    logic [31:0]        lost_count;
    logic [31:0]        total_captured;
    logic               last;
  } rsp_item_t;

  // One stored fault record; seq of zero marks an empty slot.
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] time_ms;
    logic [3:0]  kind;
    logic [7:0]  cpu;
    logic [31:0] pid;
    logic [31:0] code;
    logic [63:0] pc;
    logic [63:0] addr;
  } rec_t;

  typedef struct packed {
    logic     latch_in;
    logic     clear_step;
    logic     cap_commit;
    logic     rd_issue;
    logic     drn_init;
    logic     drn_issue;
    logic     pend_load;
    logic     out_load;
    out_sel_t out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic clear_done;
    logic drn_done;
    logic rd_empty;
    logic pend_valid;
  } ctrl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/erl_req_if.sv
// Request channel: valid/ready handshake carrying one command item.
`default_nettype none

interface erl_req_if;
  import erl_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/erl_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
`default_nettype none

interface erl_rsp_if;
  import erl_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/erl_ctrl.sv
// Controller state machine that sequences captures, reads and drains.
`default_nettype none

module erl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_cmd,
  input  erl_pkg::ctrl_stat_t stat,
  output erl_pkg::ctrl_cmd_t  cmd,
  output logic                ready
);
  import erl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req_cmd == CMD_CAPTURE) begin
            state_next = S_CAP;
          end else if (req_cmd == CMD_READ) begin
            state_next = S_READ;
          end else if (req_cmd == CMD_DRAIN) begin
            state_next = S_DRN_INIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CAP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_READ:      state_next = S_READ_WAIT;
      S_READ_WAIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_DRN_INIT:  state_next = S_DRN_RD;
      S_DRN_RD: begin
        state_next = stat.drn_done ? S_DRN_END : S_DRN_CHK;
      end
      S_DRN_CHK: begin
        if (stat.rd_empty || !stat.pend_valid || stat.out_free) state_next = S_DRN_RD;
      end
      S_DRN_END: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.out_sel = OUT_CAP;
    ready   = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        ready        = 1'b1;
        cmd.latch_in = req_valid;
      end
      S_CAP: begin
        cmd.cap_commit = stat.out_free;
        cmd.out_load   = stat.out_free;
        cmd.out_sel    = OUT_CAP;
      end
      S_READ: cmd.rd_issue = 1'b1;
      S_READ_WAIT: begin
        cmd.out_load = stat.out_free;
        cmd.out_sel  = OUT_READ;
      end
      S_DRN_INIT: cmd.drn_init = 1'b1;
      S_DRN_RD:   cmd.drn_issue = !stat.drn_done;
      S_DRN_CHK: begin
        // Hand the held record out before taking the new one.
        if (!stat.rd_empty) begin
          if (!stat.pend_valid) begin
            cmd.pend_load = 1'b1;
          end else if (stat.out_free) begin
            cmd.pend_load = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_sel   = OUT_PEND_MID;
          end
        end
      end
      S_DRN_END: begin
        cmd.out_load = stat.out_free;
        cmd.out_sel  = stat.pend_valid ? OUT_PEND_LAST : OUT_EMPTY;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/erl_dpath.sv
// Datapath: record memory, sequence and delivery counters, output register.
`default_nettype none

module erl_dpath #(
  parameter int RING_DEPTH = 32,
  parameter int KIND_COUNT = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  erl_pkg::req_item_t  req_data,
  input  erl_pkg::ctrl_cmd_t  cmd,
  output erl_pkg::ctrl_stat_t stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output erl_pkg::rsp_item_t  rsp_data
);
  import erl_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int SW1    = SLOT_W + 1;
  localparam int DIFF_W = SLOT_W + 6;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
  localparam logic [31:0]       DEPTH32   = 32'(RING_DEPTH);
  localparam logic [SLOT_W:0]   DEPTH_X   = SW1'(RING_DEPTH);
  localparam longint unsigned   WRAP_REM_L = 64'h1_0000_0000 % RING_DEPTH;
  localparam logic [SLOT_W:0]   WRAP_REM  = SW1'(WRAP_REM_L);
  localparam logic [3:0]        KIND_MAX  = 4'(KIND_COUNT - 1);

  function automatic rsp_item_t rec_to_rsp(rec_t r);
    rsp_item_t o;
    o            = '0;
    o.valid_res  = 1'b1;
    o.seq_out    = r.seq;
    o.time_out   = r.time_ms;
    o.kind_out   = r.kind;
    o.cpu_out    = r.cpu;
    o.pid_out    = r.pid;
    o.code_out   = r.code;
    o.pc_out     = r.pc;
    o.addr_out   = r.addr;
    return o;
  endfunction

  rec_t mem [RING_DEPTH];

  req_item_t          cur;
  logic [31:0]        next_seq;
  logic [31:0]        cap_total;
  logic [31:0]        dlv_total;
  logic [31:0]        lost;
  logic [SLOT_W-1:0]  nxt_slot;
  logic [SLOT_W-1:0]  new_slot;
  logic [SLOT_W-1:0]  dlv_slot;
  logic [SLOT_W-1:0]  clr_addr;
  logic [DRN_CW-1:0]  emitted;
  logic               pend_valid;
  rec_t               pend;
  rec_t               rdata;
  logic               rd_ok;

  logic [31:0]        newest;
  logic [31:0]        idx32;
  logic               read_ok_c;
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  diff_mod;
  logic [SLOT_W-1:0]  rd_slot;
  logic [3:0]         kind_c;
  rec_t               cap_rec;
  logic [SLOT_W-1:0]  nxt_slot_inc;
  logic [31:0]        backlog;
  logic [SLOT_W:0]    skip_sum;
  logic [SLOT_W:0]    skip_mod;
  logic [SLOT_W-1:0]  skip_slot;
  logic [31:0]        dlv_plus;
  logic [SLOT_W-1:0]  dlv_slot_inc;
  logic [DRN_CW-1:0]  drn_count;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  rec_t               mem_wdata;
  logic [SLOT_W-1:0]  mem_raddr;
  rsp_item_t          out_next;

  // Read addressing: newest-first index back from the newest slot.
  assign newest    = next_seq - 32'd1;
  assign idx32     = 32'(cur.read_index);
  assign read_ok_c = (idx32 < DEPTH32) && (newest != 32'd0) && (idx32 < newest);
  assign diff      = DIFF_W'(new_slot) - DIFF_W'(cur.read_index);
  assign diff_mod  = diff[DIFF_W-1] ? diff + DIFF_W'(RING_DEPTH) : diff;
  assign rd_slot   = read_ok_c ? diff_mod[SLOT_W-1:0] : '0;

  // Clamp negative or out-of-range kinds to the last kind.
  assign kind_c = (cur.kind_in[7] || (cur.kind_in[6:0] >= 7'(KIND_COUNT))) ?
                  KIND_MAX : cur.kind_in[3:0];

  always_comb begin
    cap_rec         = '0;
    cap_rec.seq     = next_seq;
    cap_rec.time_ms = cur.time_ms;
    cap_rec.kind    = kind_c;
    cap_rec.cpu     = cur.cpu_id;
    cap_rec.pid     = cur.proc_id;
    cap_rec.code    = cur.fault_code;
    cap_rec.pc      = cur.prog_counter;
    cap_rec.addr    = cur.fault_addr;
  end

  // Slot of a sequence restarts at zero when the 32-bit sequence wraps.
  assign nxt_slot_inc = (next_seq == '1) ? '0 :
                        (nxt_slot == LAST_SLOT) ? '0 : nxt_slot + 1'b1;

  // Skip over overwritten records: slot of (next_seq - depth) mod 2^32.
  assign backlog   = cap_total - dlv_total;
  assign skip_sum  = SW1'(nxt_slot) + WRAP_REM;
  assign skip_mod  = (skip_sum >= DEPTH_X) ? skip_sum - DEPTH_X : skip_sum;
  assign skip_slot = (next_seq >= DEPTH32) ? nxt_slot : skip_mod[SLOT_W-1:0];

  assign dlv_plus     = dlv_total + 32'd1;
  assign dlv_slot_inc = (dlv_plus == '1) ? '0 :
                        (dlv_slot == LAST_SLOT) ? '0 : dlv_slot + 1'b1;

  assign drn_count = emitted + DRN_CW'(pend_valid);

  assign stat.out_free   = !rsp_valid || rsp_ready;
  assign stat.clear_done = (clr_addr == LAST_SLOT);
  assign stat.drn_done   = (cap_total == dlv_total) || (drn_count == DRN_CW'(MAX_DRAIN));
  assign stat.rd_empty   = (rdata.seq == 32'd0);
  assign stat.pend_valid = pend_valid;

  assign mem_we    = cmd.clear_step || cmd.cap_commit;
  assign mem_waddr = cmd.clear_step ? clr_addr : nxt_slot;
  assign mem_wdata = cmd.clear_step ? rec_t'('0) : cap_rec;
  assign mem_raddr = cmd.drn_issue ? dlv_slot : rd_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_issue || cmd.drn_issue) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    out_next                = '0;
    out_next.total_captured = cap_total;
    out_next.last           = 1'b1;
    case (cmd.out_sel)
      OUT_CAP: begin
        out_next                = rec_to_rsp(cap_rec);
        out_next.total_captured = cap_total + 32'd1;
        out_next.last           = 1'b1;
      end
      OUT_READ: begin
        if (rd_ok && (rdata.seq != 32'd0)) begin
          out_next = rec_to_rsp(rdata);
        end
        out_next.total_captured = cap_total;
        out_next.last           = 1'b1;
      end
      OUT_PEND_MID: begin
        out_next                = rec_to_rsp(pend);
        out_next.lost_count     = lost;
        out_next.total_captured = cap_total;
        out_next.last           = 1'b0;
      end
      OUT_PEND_LAST: begin
        out_next                = rec_to_rsp(pend);
        out_next.lost_count     = lost;
        out_next.total_captured = cap_total;
        out_next.last           = 1'b1;
      end
      OUT_EMPTY: begin
        out_next.lost_count = lost;
      end
      default: out_next = '0;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur <= req_data;
    end
    if (cmd.rd_issue) begin
      rd_ok <= read_ok_c;
    end
    if (cmd.drn_init) begin
      lost <= (backlog > DEPTH32) ? backlog - DEPTH32 : 32'd0;
    end
    if (cmd.pend_load) begin
      pend <= rdata;
    end
    if (cmd.out_load) begin
      rsp_data <= out_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq   <= 32'd1;
      cap_total  <= '0;
      dlv_total  <= '0;
      nxt_slot   <= SLOT_W'(1);
      new_slot   <= '0;
      dlv_slot   <= SLOT_W'(1);
      clr_addr   <= '0;
      emitted    <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.cap_commit) begin
        next_seq  <= next_seq + 32'd1;
        cap_total <= cap_total + 32'd1;
        new_slot  <= nxt_slot;
        nxt_slot  <= nxt_slot_inc;
      end
      if (cmd.drn_init) begin
        emitted    <= '0;
        pend_valid <= 1'b0;
        if (backlog > DEPTH32) begin
          dlv_total <= cap_total - DEPTH32;
          dlv_slot  <= skip_slot;
        end
      end
      if (cmd.drn_issue) begin
        dlv_total <= dlv_plus;
        dlv_slot  <= dlv_slot_inc;
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          emitted <= emitted + 1'b1;
        end
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/event_record_ring_log.sv
// Fault record ring log: overwriting circular store of fault records.
//
// Channels: req (sink) carries one command per transfer: capture, read or
// drain. rsp (source) returns the results: one for capture and read, one to
// 32 for a drain, the final one flagged by last. Command code 3 is taken and
// yields nothing.
// Timing: the control loop handles one command at a time; req.ready is high
// only while idle. A read makes one registered memory read. A drain visits
// slots in turn, each slot being one read of the record memory, with up to
// RING_DEPTH slots walked. A result sits in an output register, so the next
// command is taken while it waits; if rsp stalls, the engine holds until the
// register frees.
// Reset: counters return to sequence 1 and no deliveries, then a clearing
// pass marks every slot empty; req.ready stays low during that pass.
`default_nettype none

module event_record_ring_log #(
  parameter int RING_DEPTH = 32,
  parameter int KIND_COUNT = 7
) (
  input logic       clk,
  input logic       rst,
  erl_req_if.sink   req,
  erl_rsp_if.source rsp
);
  import erl_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       ready;

  assign req.ready = ready;

  erl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.data.command),
    .stat      (stat),
    .cmd       (cmd),
    .ready     (ready)
  );

  erl_dpath #(
    .RING_DEPTH (RING_DEPTH),
    .KIND_COUNT (KIND_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register loaded while a result is still pending");

  a_cap_once: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_commit |-> cmd.out_load && (cmd.out_sel == OUT_CAP))
    else $error("capture committed without its acknowledgment");

  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.pend_load && stat.pend_valid) |-> cmd.out_load)
    else $error("held drain record overwritten before transfer");

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !req.ready)
    else $error("request taken during clearing pass");

endmodule

`default_nettype wire
